// File: src/i2cms_pkg.sv
// Shared types, codes and flag masks for the I2C master transfer sequencer.
// No dependencies; every other file refers to it by scoped names.
package i2cms_pkg;

    localparam int COUNT_WIDTH_DEF = 8;

    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 4;

    typedef enum logic [1:0] {
        MODE_START_WR = 2'd0,
        MODE_START_RD = 2'd1,
        MODE_STATUS   = 2'd2,
        MODE_RSVD     = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ACT_NONE      = 4'd0,
        ACT_START_WR  = 4'd1,
        ACT_START_RD  = 4'd2,
        ACT_SEND      = 4'd3,
        ACT_SEND_LAST = 4'd4,
        ACT_LAST      = 4'd5,
        ACT_ACK       = 4'd6,
        ACT_NACK_STOP = 4'd7,
        ACT_CLEAR     = 4'd8,
        ACT_RESET     = 4'd9
    } t_action;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_WR_ACT  = 6'b000010,
        ST_WR_DONE = 6'b000100,
        ST_RD_ACT  = 6'b001000,
        ST_RD_DONE = 6'b010000,
        ST_ERROR   = 6'b100000
    } t_state;

    localparam logic [2:0] DRV_IDLE    = 3'd0;
    localparam logic [2:0] DRV_WR_ACT  = 3'd1;
    localparam logic [2:0] DRV_WR_DONE = 3'd2;
    localparam logic [2:0] DRV_RD_ACT  = 3'd3;
    localparam logic [2:0] DRV_RD_DONE = 3'd4;
    localparam logic [2:0] DRV_ERROR   = 3'd5;

    localparam logic FAULT_NONE     = 1'b0;
    localparam logic FAULT_NO_REACT = 1'b1;

    localparam logic [9:0] F_BUSY     = 10'h001;
    localparam logic [9:0] F_TXREQ    = 10'h002;
    localparam logic [9:0] F_LINEFREE = 10'h004;
    localparam logic [9:0] F_BUSERR   = 10'h008;
    localparam logic [9:0] F_STOP     = 10'h010;
    localparam logic [9:0] F_STRETCH  = 10'h020;
    localparam logic [9:0] F_RW       = 10'h040;
    localparam logic [9:0] F_ACK      = 10'h080;
    localparam logic [9:0] F_RXREQ    = 10'h100;
    localparam logic [9:0] F_ADDRDATA = 10'h200;

    localparam logic [9:0] F_COMMON  = F_BUSERR | F_BUSY | F_STOP | F_STRETCH | F_RW;
    localparam logic [9:0] START_CARE = F_BUSY | F_TXREQ | F_LINEFREE;
    localparam logic [9:0] START_WANT = F_TXREQ | F_LINEFREE;
    localparam logic [9:0] WR_CARE    = F_COMMON | F_ACK | F_TXREQ;
    localparam logic [9:0] WR_WANT    = F_BUSY | F_STRETCH | F_TXREQ;
    localparam logic [9:0] RDACK_CARE = F_COMMON | F_RXREQ | F_ACK;
    localparam logic [9:0] RDACK_WANT = F_BUSY | F_STRETCH | F_RW;
    localparam logic [9:0] RDDAT_CARE = F_COMMON | F_RXREQ | F_ADDRDATA;
    localparam logic [9:0] RDDAT_WANT = F_BUSY | F_STRETCH | F_RW | F_RXREQ;

    typedef struct packed {
        t_mode      mode;
        logic [6:0] slave_address;
        logic [7:0] byte_count;
        logic [9:0] status_flags;
        logic [7:0] tx_byte;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        t_state     state;
        logic [6:0] target_address;
        logic       fault_code;
    } t_ctx;

    typedef struct packed {
        t_action    action;
        logic [6:0] bus_address;
        logic [7:0] tx_data;
        logic [7:0] rx_data;
        logic       rx_valid;
        logic [2:0] driver_state;
        logic       error_code;
        logic [7:0] remaining;
    } t_out;

    function automatic logic [2:0] drv_code(t_state s);
        logic [2:0] c;
        case (s)
            ST_IDLE:    c = DRV_IDLE;
            ST_WR_ACT:  c = DRV_WR_ACT;
            ST_WR_DONE: c = DRV_WR_DONE;
            ST_RD_ACT:  c = DRV_RD_ACT;
            ST_RD_DONE: c = DRV_RD_DONE;
            ST_ERROR:   c = DRV_ERROR;
            default:    c = DRV_IDLE;
        endcase
        return c;
    endfunction

endpackage

// File: src/i2c_master_transfer_sequencer.sv
// Top level of the I2C master transfer sequencer: input register, sequencer
// state, result register. Depends on i2cms_pkg and i2cms_step.
//
//  channel | dir | handshake             | tuser       | tdata
//  s       | in  | i_s_tvalid/o_s_tready | mode        | address,count,flags,tx,rx
//  m       | out | o_m_tvalid/i_m_tready | action      | address,tx,rx,rx_valid,...
//
// One word per cycle sustained while i_m_tready is high; a result is shown after its word
// passes the input register, then the result register, with the state update in between.
// Reset clears the sequencer state, counter, address, fault and both valid flags.
// When the result register is held by a low i_m_tready, the input register
// fills and o_s_tready drops until the result is taken.
module i2c_master_transfer_sequencer #(
    parameter int COUNT_WIDTH = i2cms_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [6:0] slave_address, [14:7] byte_count, [24:15] status_flags,
    // [32:25] tx_byte, [40:33] rx_byte, [47:41] zero
    input  logic [i2cms_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // [1:0] mode
    input  logic [i2cms_pkg::IN_USER_W-1:0]  i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [6:0] bus_address, [14:7] tx_data, [22:15] rx_data, [23] rx_valid,
    // [26:24] driver_state, [27] error_code, [35:28] remaining, [39:36] zero
    output logic [i2cms_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // [3:0] action
    output logic [i2cms_pkg::OUT_USER_W-1:0] o_m_tuser
);

    logic                   r_in_valid;
    i2cms_pkg::t_in         r_in;
    i2cms_pkg::t_in         w_item;
    i2cms_pkg::t_ctx        r_ctx;
    i2cms_pkg::t_ctx        n_ctx;
    logic [COUNT_WIDTH-1:0] r_left;
    logic [COUNT_WIDTH-1:0] n_left;
    logic                   r_out_valid;
    i2cms_pkg::t_out        r_out;
    i2cms_pkg::t_out        n_out;
    logic                   w_adv;

    assign w_item.mode          = i2cms_pkg::t_mode'(i_s_tuser[1:0]);
    assign w_item.slave_address = i_s_tdata[6:0];
    assign w_item.byte_count    = i_s_tdata[14:7];
    assign w_item.status_flags  = i_s_tdata[24:15];
    assign w_item.tx_byte       = i_s_tdata[32:25];
    assign w_item.rx_byte       = i_s_tdata[40:33];

    assign w_adv      = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || w_adv;

    i2cms_step #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_step (
        .i_item       (r_in),
        .i_ctx        (r_ctx),
        .i_bytes_left (r_left),
        .o_ctx        (n_ctx),
        .o_bytes_left (n_left),
        .o_result     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx.state          <= i2cms_pkg::ST_IDLE;
            r_ctx.target_address <= '0;
            r_ctx.fault_code     <= i2cms_pkg::FAULT_NONE;
            r_left               <= '0;
            r_out_valid          <= 1'b0;
        end else if (r_in_valid && w_adv) begin
            r_ctx       <= n_ctx;
            r_left      <= n_left;
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.action;
    assign o_m_tdata  = {4'b0000, r_out.remaining, r_out.error_code, r_out.driver_state,
                         r_out.rx_valid, r_out.rx_data, r_out.tx_data, r_out.bus_address};

endmodule

// File: src/i2cms_step.sv
// Next-state and result logic for one word of the transfer sequencer.
// Depends on i2cms_pkg.
module i2cms_step #(
    parameter int COUNT_WIDTH = i2cms_pkg::COUNT_WIDTH_DEF
) (
    input  i2cms_pkg::t_in          i_item,
    input  i2cms_pkg::t_ctx         i_ctx,
    input  logic [COUNT_WIDTH-1:0]  i_bytes_left,
    output i2cms_pkg::t_ctx         o_ctx,
    output logic [COUNT_WIDTH-1:0]  o_bytes_left,
    output i2cms_pkg::t_out         o_result
);

    always_comb begin
        i2cms_pkg::t_ctx        ctx;
        logic [COUNT_WIDTH-1:0] left;
        i2cms_pkg::t_action     act;
        logic [6:0]             baddr;
        logic [7:0]             txd;
        logic [7:0]             rxd;
        logic                   rxv;
        logic                   sent;
        logic [9:0]             fl;

        ctx   = i_ctx;
        left  = i_bytes_left;
        act   = i2cms_pkg::ACT_NONE;
        baddr = '0;
        txd   = '0;
        rxd   = '0;
        rxv   = 1'b0;
        sent  = 1'b0;
        fl    = i_item.status_flags;

        case (i_item.mode)
            i2cms_pkg::MODE_START_WR, i2cms_pkg::MODE_START_RD: begin
                ctx.target_address = i_item.slave_address;
                left = COUNT_WIDTH'(i_item.byte_count);
                if ((fl & i2cms_pkg::START_CARE) == i2cms_pkg::START_WANT) begin
                    if (i_item.mode == i2cms_pkg::MODE_START_WR) begin
                        ctx.state = i2cms_pkg::ST_WR_ACT;
                        act = i2cms_pkg::ACT_START_WR;
                    end else begin
                        ctx.state = i2cms_pkg::ST_RD_ACT;
                        act = i2cms_pkg::ACT_START_RD;
                    end
                    baddr = i_item.slave_address;
                end else begin
                    ctx.state = i2cms_pkg::ST_ERROR;
                    ctx.fault_code = i2cms_pkg::FAULT_NO_REACT;
                end
            end
            i2cms_pkg::MODE_STATUS: begin
                case (i_ctx.state)
                    i2cms_pkg::ST_WR_ACT: begin
                        if ((fl & i2cms_pkg::WR_CARE) == i2cms_pkg::WR_WANT) begin
                            if (i_bytes_left != '0) begin
                                txd  = i_item.tx_byte;
                                left = i_bytes_left - COUNT_WIDTH'(1);
                                sent = 1'b1;
                            end
                            if (left == '0) begin
                                act = sent ? i2cms_pkg::ACT_SEND_LAST : i2cms_pkg::ACT_LAST;
                            end else begin
                                act = i2cms_pkg::ACT_SEND;
                            end
                        end else if ((fl & i2cms_pkg::F_STOP) != '0) begin
                            if ((fl & i2cms_pkg::F_BUSERR) != '0 || i_bytes_left != '0) begin
                                ctx.state = i2cms_pkg::ST_ERROR;
                                ctx.fault_code = i2cms_pkg::FAULT_NO_REACT;
                            end else begin
                                ctx.state = i2cms_pkg::ST_WR_DONE;
                                act = i2cms_pkg::ACT_CLEAR;
                            end
                        end
                    end
                    i2cms_pkg::ST_RD_ACT: begin
                        if ((fl & i2cms_pkg::RDACK_CARE) == i2cms_pkg::RDACK_WANT) begin
                            act = i2cms_pkg::ACT_ACK;
                        end else if ((fl & i2cms_pkg::RDDAT_CARE) == i2cms_pkg::RDDAT_WANT) begin
                            act = (i_bytes_left == COUNT_WIDTH'(1)) ?
                                  i2cms_pkg::ACT_NACK_STOP : i2cms_pkg::ACT_ACK;
                            rxd = i_item.rx_byte;
                            rxv = 1'b1;
                            if (i_bytes_left != '0) begin
                                left = i_bytes_left - COUNT_WIDTH'(1);
                            end
                        end else if ((fl & i2cms_pkg::F_STOP) != '0) begin
                            if ((fl & i2cms_pkg::F_BUSERR) != '0 || i_bytes_left != '0) begin
                                ctx.state = i2cms_pkg::ST_ERROR;
                                ctx.fault_code = i2cms_pkg::FAULT_NO_REACT;
                            end else begin
                                ctx.state = i2cms_pkg::ST_RD_DONE;
                                act = i2cms_pkg::ACT_CLEAR;
                            end
                        end
                    end
                    i2cms_pkg::ST_WR_DONE, i2cms_pkg::ST_RD_DONE: begin
                        ctx.state = i2cms_pkg::ST_IDLE;
                    end
                    i2cms_pkg::ST_ERROR: begin
                        ctx.state = i2cms_pkg::ST_IDLE;
                        ctx.target_address = '0;
                        ctx.fault_code = i2cms_pkg::FAULT_NONE;
                        left = '0;
                        act = i2cms_pkg::ACT_RESET;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        o_ctx        = ctx;
        o_bytes_left = left;
        o_result.action       = act;
        o_result.bus_address  = baddr;
        o_result.tx_data      = txd;
        o_result.rx_data      = rxd;
        o_result.rx_valid     = rxv;
        o_result.driver_state = i2cms_pkg::drv_code(ctx.state);
        o_result.error_code   = ctx.fault_code;
        o_result.remaining    = 8'(left);
    end

endmodule

// File: src/i2cms_checker.sv
// Port-level checks for the I2C master transfer sequencer and their bind.
// Depends on i2cms_pkg and the top level i2c_master_transfer_sequencer.
module i2cms_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [i2cms_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic [i2cms_pkg::OUT_USER_W-1:0] o_m_tuser
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result word changed while stalled");

    a_rx_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[23] |->
            o_m_tuser == i2cms_pkg::ACT_ACK || o_m_tuser == i2cms_pkg::ACT_NACK_STOP)
        else $error("received byte without ack or nack");

    a_error_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[26:24] == i2cms_pkg::DRV_ERROR |-> o_m_tdata[27])
        else $error("error state without fault code");

    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == i2cms_pkg::ACT_RESET |->
            o_m_tdata[26:24] == i2cms_pkg::DRV_IDLE && !o_m_tdata[27]
            && o_m_tdata[35:28] == 8'd0)
        else $error("controller reset did not clear sequencer");

endmodule

bind i2c_master_transfer_sequencer i2cms_checker u_i2cms_checker (.*);

// File: bench/testbench.sv
// Self-checking bench for the I2C master transfer sequencer: directed and random
// start/status words streamed in, every result checked against a local model.
// Depends on i2cms_pkg and i2c_master_transfer_sequencer.
module testbench;

    localparam logic [9:0] XFER_COMMON = i2cms_pkg::F_BUSERR | i2cms_pkg::F_BUSY
                                         | i2cms_pkg::F_STOP | i2cms_pkg::F_STRETCH
                                         | i2cms_pkg::F_RW;
    localparam logic [9:0] GRANT_CARE  = i2cms_pkg::F_BUSY | i2cms_pkg::F_TXREQ
                                         | i2cms_pkg::F_LINEFREE;
    localparam logic [9:0] GRANT_WANT  = i2cms_pkg::F_TXREQ | i2cms_pkg::F_LINEFREE;
    localparam logic [9:0] SEND_CARE   = XFER_COMMON | i2cms_pkg::F_ACK | i2cms_pkg::F_TXREQ;
    localparam logic [9:0] SEND_WANT   = i2cms_pkg::F_BUSY | i2cms_pkg::F_STRETCH
                                         | i2cms_pkg::F_TXREQ;
    localparam logic [9:0] RXACK_CARE  = XFER_COMMON | i2cms_pkg::F_RXREQ | i2cms_pkg::F_ACK;
    localparam logic [9:0] RXACK_WANT  = i2cms_pkg::F_BUSY | i2cms_pkg::F_STRETCH
                                         | i2cms_pkg::F_RW;
    localparam logic [9:0] RXDAT_CARE  = XFER_COMMON | i2cms_pkg::F_RXREQ
                                         | i2cms_pkg::F_ADDRDATA;
    localparam logic [9:0] RXDAT_WANT  = i2cms_pkg::F_BUSY | i2cms_pkg::F_STRETCH
                                         | i2cms_pkg::F_RW | i2cms_pkg::F_RXREQ;
    localparam int         WORD_TARGET = 1275;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [i2cms_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic [i2cms_pkg::IN_USER_W-1:0]  s_tuser = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [i2cms_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [i2cms_pkg::OUT_USER_W-1:0] m_tuser;

    i2cms_pkg::t_in  queued_words[$];
    i2cms_pkg::t_out awaited_results[$];
    i2cms_pkg::t_in  shown_word = '0;
    int              error_count = 0;

    logic [2:0] seq_state = i2cms_pkg::DRV_IDLE;
    logic [7:0] count_left = '0;
    logic [6:0] addr_held = '0;
    logic       fault_held = i2cms_pkg::FAULT_NONE;

    i2c_master_transfer_sequencer uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic i2cms_pkg::t_out next_sequencer_result(i2cms_pkg::t_in w);
        i2cms_pkg::t_out r;
        logic [9:0]      f;
        logic            sent;
        r = '0;
        r.action = i2cms_pkg::ACT_NONE;
        f = w.status_flags;
        sent = 1'b0;
        case (w.mode)
            i2cms_pkg::MODE_START_WR, i2cms_pkg::MODE_START_RD: begin
                addr_held = w.slave_address;
                count_left = w.byte_count;
                if ((f & GRANT_CARE) == GRANT_WANT) begin
                    if (w.mode == i2cms_pkg::MODE_START_WR) begin
                        seq_state = i2cms_pkg::DRV_WR_ACT;
                        r.action = i2cms_pkg::ACT_START_WR;
                    end else begin
                        seq_state = i2cms_pkg::DRV_RD_ACT;
                        r.action = i2cms_pkg::ACT_START_RD;
                    end
                    r.bus_address = addr_held;
                end else begin
                    seq_state = i2cms_pkg::DRV_ERROR;
                    fault_held = i2cms_pkg::FAULT_NO_REACT;
                end
            end
            i2cms_pkg::MODE_STATUS: begin
                case (seq_state)
                    i2cms_pkg::DRV_WR_ACT, i2cms_pkg::DRV_RD_ACT: begin
                        if (seq_state == i2cms_pkg::DRV_WR_ACT
                            && (f & SEND_CARE) == SEND_WANT) begin
                            if (count_left != 8'd0) begin
                                r.tx_data = w.tx_byte;
                                count_left = count_left - 8'd1;
                                sent = 1'b1;
                            end
                            if (count_left != 8'd0) r.action = i2cms_pkg::ACT_SEND;
                            else if (sent)          r.action = i2cms_pkg::ACT_SEND_LAST;
                            else                    r.action = i2cms_pkg::ACT_LAST;
                        end else if (seq_state == i2cms_pkg::DRV_RD_ACT
                                     && (f & RXACK_CARE) == RXACK_WANT) begin
                            r.action = i2cms_pkg::ACT_ACK;
                        end else if (seq_state == i2cms_pkg::DRV_RD_ACT
                                     && (f & RXDAT_CARE) == RXDAT_WANT) begin
                            r.action = (count_left == 8'd1) ? i2cms_pkg::ACT_NACK_STOP
                                                            : i2cms_pkg::ACT_ACK;
                            r.rx_data = w.rx_byte;
                            r.rx_valid = 1'b1;
                            if (count_left != 8'd0) count_left = count_left - 8'd1;
                        end else if ((f & i2cms_pkg::F_STOP) != 10'd0) begin
                            if ((f & i2cms_pkg::F_BUSERR) != 10'd0 || count_left != 8'd0) begin
                                seq_state = i2cms_pkg::DRV_ERROR;
                                fault_held = i2cms_pkg::FAULT_NO_REACT;
                            end else begin
                                seq_state = (seq_state == i2cms_pkg::DRV_WR_ACT)
                                            ? i2cms_pkg::DRV_WR_DONE
                                            : i2cms_pkg::DRV_RD_DONE;
                                r.action = i2cms_pkg::ACT_CLEAR;
                            end
                        end
                    end
                    i2cms_pkg::DRV_WR_DONE, i2cms_pkg::DRV_RD_DONE: begin
                        seq_state = i2cms_pkg::DRV_IDLE;
                    end
                    i2cms_pkg::DRV_ERROR: begin
                        seq_state = i2cms_pkg::DRV_IDLE;
                        count_left = '0;
                        addr_held = '0;
                        fault_held = i2cms_pkg::FAULT_NONE;
                        r.action = i2cms_pkg::ACT_RESET;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.driver_state = seq_state;
        r.error_code = fault_held;
        r.remaining = count_left;
        return r;
    endfunction

    function automatic logic [9:0] rule_flags(logic [9:0] want, logic [9:0] care);
        logic [9:0] noise;
        noise = 10'($urandom);
        return want | (noise & ~care);
    endfunction

    task automatic add_word(i2cms_pkg::t_mode m, int unsigned addr, int unsigned cnt,
                            int unsigned flags, int unsigned tx, int unsigned rx);
        i2cms_pkg::t_in w;
        w.mode = m;
        w.slave_address = addr[6:0];
        w.byte_count = cnt[7:0];
        w.status_flags = flags[9:0];
        w.tx_byte = tx[7:0];
        w.rx_byte = rx[7:0];
        queued_words.push_back(w);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    initial begin : stimulus
        int unsigned count;
        int unsigned steps;
        int unsigned roll;
        logic [9:0]  flags;
        logic        is_read;
        logic        broken;

        // idle status, reserved mode, then a clean two-byte write
        add_word(i2cms_pkg::MODE_STATUS, 0, 0, 0, 0, 0);
        add_word(i2cms_pkg::MODE_RSVD, 127, 255, 10'h3FF, 255, 255);
        add_word(i2cms_pkg::MODE_START_WR, 127, 2, GRANT_WANT, 0, 0);
        add_word(i2cms_pkg::MODE_STATUS, 0, 0, SEND_WANT, 8'hFF, 0);
        add_word(i2cms_pkg::MODE_STATUS, 0, 0,
                 SEND_WANT | i2cms_pkg::F_LINEFREE | i2cms_pkg::F_RXREQ
                 | i2cms_pkg::F_ADDRDATA, 0, 8'hFF);
        add_word(i2cms_pkg::MODE_STATUS, 0, 0, SEND_WANT, 8'hA5, 0);
        add_word(i2cms_pkg::MODE_STATUS, 0, 0, SEND_WANT | i2cms_pkg::F_ACK, 8'h5A, 0);
        add_word(i2cms_pkg::MODE_STATUS, 0, 0, i2cms_pkg::F_STOP, 0, 0);
        add_word(i2cms_pkg::MODE_STATUS, 0, 0, 0, 0, 0);
        // read with leftover count, error exit, then reset
        add_word(i2cms_pkg::MODE_START_RD, 0, 255, GRANT_WANT | 10'h3F8, 255, 255);
        add_word(i2cms_pkg::MODE_STATUS, 0, 0, RXACK_WANT | i2cms_pkg::F_ADDRDATA, 0, 8'h3C);
        add_word(i2cms_pkg::MODE_STATUS, 0, 0, RXDAT_WANT, 0, 8'hFF);
        add_word(i2cms_pkg::MODE_STATUS, 0, 0, i2cms_pkg::F_STOP, 0, 0);
        add_word(i2cms_pkg::MODE_STATUS, 0, 0, 10'h3FF, 255, 255);
        // one-byte read, extra byte at zero count, bus error on stop
        add_word(i2cms_pkg::MODE_START_RD, 42, 1, GRANT_WANT, 0, 0);
        add_word(i2cms_pkg::MODE_STATUS, 0, 0, RXDAT_WANT, 0, 8'h81);
        add_word(i2cms_pkg::MODE_STATUS, 0, 0,
                 RXDAT_WANT | i2cms_pkg::F_ACK | i2cms_pkg::F_TXREQ, 0, 8'h7E);
        add_word(i2cms_pkg::MODE_STATUS, 0, 0, i2cms_pkg::F_STOP | i2cms_pkg::F_BUSERR, 0, 0);
        add_word(i2cms_pkg::MODE_STATUS, 0, 0, 0, 0, 0);
        // refused start, then starts that replace the transfer while faulted
        add_word(i2cms_pkg::MODE_START_WR, 9, 4,
                 i2cms_pkg::F_BUSY | i2cms_pkg::F_TXREQ | i2cms_pkg::F_LINEFREE, 0, 0);
        add_word(i2cms_pkg::MODE_START_WR, 100, 0, GRANT_WANT, 0, 0);
        add_word(i2cms_pkg::MODE_START_RD, 7'h55, 3, GRANT_WANT, 0, 0);
        add_word(i2cms_pkg::MODE_STATUS, 0, 0, i2cms_pkg::F_STOP, 0, 0);
        add_word(i2cms_pkg::MODE_STATUS, 0, 0, 0, 0, 0);

        while (queued_words.size() < WORD_TARGET) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
                repeat ($urandom_range(1, 6))
                    add_word(i2cms_pkg::t_mode'($urandom_range(0, 3)), $urandom, $urandom,
                             $urandom, $urandom, $urandom);
            end else begin
                broken = (roll == 1);
                is_read = 1'($urandom_range(0, 1));
                count = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 6);
                if ($urandom_range(0, 9) == 0) begin
                    flags = 10'($urandom);
                    if ((flags & GRANT_CARE) == GRANT_WANT) flags = flags | i2cms_pkg::F_BUSY;
                end else begin
                    flags = rule_flags(GRANT_WANT, GRANT_CARE);
                end
                add_word(is_read ? i2cms_pkg::MODE_START_RD : i2cms_pkg::MODE_START_WR,
                         $urandom, count, flags, $urandom, $urandom);
                steps = (count > 8) ? $urandom_range(0, 8) : count + $urandom_range(0, 1);
                if (steps > 0 && $urandom_range(0, 5) == 0) steps = steps - 1;
                if (broken) steps = $urandom_range(0, 3);
                repeat (steps) begin
                    if ($urandom_range(0, 11) == 0) begin
                        flags = 10'($urandom);
                        add_word(i2cms_pkg::MODE_STATUS, 0, 0, flags & ~i2cms_pkg::F_STOP,
                                 $urandom, $urandom);
                    end
                    if (is_read) begin
                        if ($urandom_range(0, 1) == 0)
                            add_word(i2cms_pkg::MODE_STATUS, $urandom, $urandom,
                                     rule_flags(RXACK_WANT, RXACK_CARE), $urandom, $urandom);
                        add_word(i2cms_pkg::MODE_STATUS, $urandom, $urandom,
                                 rule_flags(RXDAT_WANT, RXDAT_CARE), $urandom, $urandom);
                    end else begin
                        add_word(i2cms_pkg::MODE_STATUS, $urandom, $urandom,
                                 rule_flags(SEND_WANT, SEND_CARE), $urandom, $urandom);
                    end
                end
                if (!broken) begin
                    flags = 10'($urandom);
                    flags = flags | i2cms_pkg::F_STOP;
                    if ($urandom_range(0, 4) != 0) flags = flags & ~i2cms_pkg::F_BUSERR;
                    add_word(i2cms_pkg::MODE_STATUS, $urandom, $urandom, flags,
                             $urandom, $urandom);
                    add_word(i2cms_pkg::MODE_STATUS, $urandom, $urandom, $urandom,
                             $urandom, $urandom);
                end
            end
        end
    end

    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(posedge clk) begin : drive
        i2cms_pkg::t_in w;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                awaited_results.push_back(next_sequencer_result(shown_word));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (queued_words.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else begin
                    if (burst_left == 0) burst_left = $urandom_range(1, 40);
                    w = queued_words.pop_front();
                    s_tdata <= {7'd0, w.rx_byte, w.tx_byte, w.status_flags,
                                w.byte_count, w.slave_address};
                    s_tuser <= w.mode;
                    shown_word <= w;
                    s_tvalid <= 1'b1;
                    burst_left = burst_left - 1;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    int unsigned hold_left = 0;
    int unsigned hold_mode = 0;

    always @(posedge clk) begin : accept
        logic ready;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_left == 0) begin
                hold_mode = $urandom_range(0, 3);
                hold_left = $urandom_range(4, 60);
            end else begin
                hold_left = hold_left - 1;
            end
            case (hold_mode)
                0:       ready = 1'b1;
                1:       ready = 1'($urandom_range(0, 1));
                2:       ready = (hold_left % 3) != 0;
                default: ready = ($urandom_range(0, 3) == 0);
            endcase
            m_tready <= ready;
        end
    end

    always @(posedge clk) begin : watch
        i2cms_pkg::t_out exp;
        if (rst_n && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                $error("result with no word pending: tuser %0d tdata %h", m_tuser, m_tdata);
                error_count++;
            end else begin
                exp = awaited_results.pop_front();
                check_field("action", exp.action, m_tuser[3:0]);
                check_field("bus_address", exp.bus_address, m_tdata[6:0]);
                check_field("tx_data", exp.tx_data, m_tdata[14:7]);
                check_field("rx_data", exp.rx_data, m_tdata[22:15]);
                check_field("rx_valid", exp.rx_valid, m_tdata[23]);
                check_field("driver_state", exp.driver_state, m_tdata[26:24]);
                check_field("error_code", exp.error_code, m_tdata[27]);
                check_field("remaining", exp.remaining, m_tdata[35:28]);
            end
        end
    end

    initial begin
        @(posedge rst_n);
        while (queued_words.size() != 0 || s_tvalid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (error_count == 0)
            $display("i2c_master_transfer_sequencer test passed");
        else
            $display("i2c_master_transfer_sequencer test failed");
        $finish;
    end

    initial begin
        #4000000;
        $display("i2c_master_transfer_sequencer test failed");
        $finish;
    end

endmodule
